// File: src/bia_pkg.sv
// shared types, constants and helpers of the bitmap index allocator
package bia_pkg;

    localparam int C_COUNT  = 1024;
    localparam int C_OFF_W  = $clog2(C_COUNT);
    localparam int C_WB     = 5;
    localparam int C_WORD_W = 1 << C_WB;
    localparam int C_WORDS  = C_COUNT / C_WORD_W;
    localparam int C_WA_W   = C_OFF_W - C_WB;
    localparam int C_IDX_W  = 17;

    localparam logic [C_IDX_W-1:0] C_NONE     = 17'h10000;
    localparam logic [C_IDX_W-1:0] C_COUNT_M1 = C_IDX_W'(C_COUNT - 1);
    localparam logic [15:0]        C_LFSR_RST = 16'hACE1;
    localparam logic [15:0]        C_DRAW_MAX = 16'hFFFE;

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_LOCK  = 3'd1;
    localparam logic [2:0] ACT_FREE  = 3'd2;
    localparam logic [2:0] ACT_TEST  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [2:0] MODE_RANDOM = 3'd0;
    localparam logic [2:0] MODE_MIN    = 3'd1;
    localparam logic [2:0] MODE_MAX    = 3'd2;
    localparam logic [2:0] MODE_PREV   = 3'd3;
    localparam logic [2:0] MODE_NEXT   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_STATE = 2'd3;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_CLO   = 2'd1;
    localparam logic [1:0] CFG_CHI   = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  alloc_mode;
        logic [15:0] req_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_index;
        logic        busy_res;
    } t_out;

    function automatic logic [C_WB-1:0] f_first_set(input logic [C_WORD_W-1:0] v);
        logic [C_WB-1:0] r;
        r = '0;
        for (int k = C_WORD_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = C_WB'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [C_WB-1:0] f_last_set(input logic [C_WORD_W-1:0] v);
        logic [C_WB-1:0] r;
        r = '0;
        for (int k = 0; k < C_WORD_W; k++) begin
            if (v[k]) begin
                r = C_WB'(k);
            end
        end
        return r;
    endfunction

endpackage

// File: src/bia_ram.sv
// generic single-port-write ram with registered read
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bia_mod.sv
// iterative remainder unit, one quotient bit per cycle
module bia_mod import bia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_num,
    input  logic [C_IDX_W-1:0] i_den,
    output logic               o_done,
    output logic [C_IDX_W-1:0] o_rem
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [15:0]        r_num;
    logic [C_IDX_W-1:0] r_rem;
    logic [C_IDX_W:0]   w_trial;
    logic [C_IDX_W:0]   w_sub;

    assign w_trial = {r_rem, r_num[15]};
    assign w_sub   = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[14:0], 1'b0};
                if (w_trial >= {1'b0, i_den}) begin
                    r_rem <= w_sub[C_IDX_W-1:0];
                end else begin
                    r_rem <= w_trial[C_IDX_W-1:0];
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: src/bitmap_index_allocator.sv
// bitmap index allocator top level
//
//  channel | direction | handshake            | beat
//  in      | input     | i_in_valid/o_in_stall | t_in: action, alloc_mode, req_index
//  out     | output    | o_out_valid/i_out_stall | t_out: status, out_index, busy_res
//  cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// test, free and try lock of a busy index pass S_RD and S_CHK (a successful free also
// S_FREEH) before S_DONE; clear, unknown actions and early rejects reach S_DONE
// without a bitmap read; an alloc or lock inside the clamp window then scans the
// bitmap words up (S_UP_RD, S_UP_CHK) and down (S_DN_SET, S_DN_RD, S_DN_CHK) and
// updates the hints in S_LOCKH; random allocation runs each draw through S_DRAW and
// the remainder unit in S_MOD; reset and base or clamp writes rebuild hints in S_INIT
// a finished beat waits in the output register while the next one is taken in
module bitmap_index_allocator import bia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [14:0] {
        S_INIT   = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_HINT   = 15'b000000000000100,
        S_DRAW   = 15'b000000000001000,
        S_MOD    = 15'b000000000010000,
        S_RD     = 15'b000000000100000,
        S_CHK    = 15'b000000001000000,
        S_UP_RD  = 15'b000000010000000,
        S_UP_CHK = 15'b000000100000000,
        S_DN_SET = 15'b000001000000000,
        S_DN_RD  = 15'b000010000000000,
        S_DN_CHK = 15'b000100000000000,
        S_LOCKH  = 15'b001000000000000,
        S_FREEH  = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state;

    logic [15:0] r_base;
    logic [15:0] r_clamp_lo;
    logic [15:0] r_clamp_hi;

    logic [C_IDX_W-1:0] r_lowest;
    logic [C_IDX_W-1:0] r_highest;
    logic [C_IDX_W-1:0] r_prev;
    logic [C_IDX_W-1:0] r_next;
    logic [C_IDX_W-1:0] r_last;
    logic [15:0]        r_lfsr;
    logic [15:0]        r_draws;
    logic [C_WORDS-1:0] r_valid;

    logic [2:0]         r_act;
    logic [2:0]         r_mode;
    logic [C_IDX_W-1:0] r_idx;
    logic [1:0]         r_status;
    logic [15:0]        r_oidx;
    logic               r_busy;
    logic [C_IDX_W-1:0] r_up;
    logic [C_IDX_W-1:0] r_dn;

    logic [C_WA_W-1:0]  r_sw;
    logic [C_WA_W-1:0]  r_ew;
    logic [C_WB-1:0]    r_sbit;
    logic [C_WB-1:0]    r_ebit;
    logic [C_WA_W-1:0]  r_qa;

    logic               r_out_valid;
    t_out               r_out;

    logic [C_IDX_W-1:0]  w_base;
    logic [C_IDX_W-1:0]  w_end;
    logic [C_IDX_W-1:0]  w_clo;
    logic [C_IDX_W-1:0]  w_chi;
    logic [C_IDX_W-1:0]  w_cap;
    logic [C_IDX_W-1:0]  w_req;
    logic [C_IDX_W-1:0]  w_req_rel;
    logic                w_req_in;
    logic                w_idx_clamp;
    logic                w_clamp_ok;
    logic [C_IDX_W-1:0]  w_idx_rel;
    logic [C_IDX_W-1:0]  w_chi_rel;
    logic [C_IDX_W-1:0]  w_clo_rel;
    logic [C_OFF_W-1:0]  w_off;
    logic [C_OFF_W-1:0]  w_up_start;
    logic [C_OFF_W-1:0]  w_up_end;
    logic [C_OFF_W-1:0]  w_dn_start;
    logic [C_OFF_W-1:0]  w_dn_end;
    logic [C_WB-1:0]     w_bit;
    logic [C_WORD_W-1:0] w_word;
    logic [C_WORD_W-1:0] w_bitmask;
    logic                w_b;
    logic                w_write;
    logic [C_WORD_W-1:0] w_wdata;
    logic [C_WA_W-1:0]   w_raddr;
    logic [C_WORD_W-1:0] w_ram_q;
    logic [C_WORD_W-1:0] w_up_free;
    logic [C_WORD_W-1:0] w_dn_free;
    logic [C_IDX_W-1:0]  w_up_hit;
    logic [C_IDX_W-1:0]  w_dn_hit;
    logic [15:0]         w_lfsr_nx;
    logic                w_div_done;
    logic [C_IDX_W-1:0]  w_div_rem;
    logic [C_IDX_W-1:0]  w_lnew;
    logic [C_IDX_W-1:0]  w_hnew;

    localparam logic [C_WORD_W-1:0] C_ONES = '1;

    // window and clamp bounds
    assign w_base     = {1'b0, r_base};
    assign w_end      = w_base + C_COUNT_M1;
    assign w_clo      = ({1'b0, r_clamp_lo} > w_base) ? {1'b0, r_clamp_lo} : w_base;
    assign w_chi      = ({1'b0, r_clamp_hi} < w_end) ? {1'b0, r_clamp_hi} : w_end;
    assign w_clamp_ok = (w_clo <= w_chi);
    assign w_cap      = w_chi - w_clo + C_IDX_W'(1);

    assign w_req      = {1'b0, i_in_data.req_index};
    assign w_req_rel  = w_req - w_base;
    assign w_req_in   = (w_req >= w_base) && (w_req_rel < C_IDX_W'(C_COUNT));

    assign w_idx_clamp = (r_idx >= w_clo) && (r_idx <= w_chi);
    assign w_idx_rel   = r_idx - w_base;
    assign w_chi_rel   = w_chi - w_base;
    assign w_clo_rel   = w_clo - w_base;
    assign w_off       = w_idx_rel[C_OFF_W-1:0];
    assign w_bit       = w_off[C_WB-1:0];
    assign w_up_start  = w_off + C_OFF_W'(1);
    assign w_up_end    = w_chi_rel[C_OFF_W-1:0];
    assign w_dn_start  = w_off - C_OFF_W'(1);
    assign w_dn_end    = w_clo_rel[C_OFF_W-1:0];

    // bitmap word as read, words never written since clear read as free
    assign w_word    = r_valid[r_qa] ? w_ram_q : '0;
    assign w_bitmask = C_WORD_W'(1) << w_bit;
    assign w_b       = w_word[w_bit];

    always_comb begin
        w_write = 1'b0;
        if (r_state == S_CHK) begin
            case (r_act)
                ACT_ALLOC, ACT_LOCK: w_write = !w_b;
                ACT_FREE:            w_write = w_b;
                default:             w_write = 1'b0;
            endcase
        end
    end

    assign w_wdata = (r_act == ACT_FREE) ? (w_word & ~w_bitmask) : (w_word | w_bitmask);
    assign w_raddr = (r_state == S_RD) ? w_off[C_OFF_W-1:C_WB] : r_sw;

    assign w_up_free = ~w_word & (C_ONES << r_sbit)
                     & ((r_sw == r_ew) ? (C_ONES >> (C_WB'(C_WORD_W - 1) - r_ebit)) : C_ONES);
    assign w_dn_free = ~w_word & (C_ONES >> (C_WB'(C_WORD_W - 1) - r_sbit))
                     & ((r_sw == r_ew) ? (C_ONES << r_ebit) : C_ONES);
    assign w_up_hit  = w_base + C_IDX_W'({r_sw, f_first_set(w_up_free)});
    assign w_dn_hit  = w_base + C_IDX_W'({r_sw, f_last_set(w_dn_free)});

    assign w_lfsr_nx = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    assign w_lnew = (r_idx == r_lowest) ? r_up : r_lowest;
    assign w_hnew = (r_idx == r_highest) ? r_dn : r_highest;

    bia_ram #(
        .WIDTH (C_WORD_W),
        .DEPTH (C_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (r_qa),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    bia_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DRAW),
        .i_num   (w_lfsr_nx),
        .i_den   (w_cap),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_base      <= '0;
            r_clamp_lo  <= '0;
            r_clamp_hi  <= 16'd1023;
            r_lfsr      <= C_LFSR_RST;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_qa <= w_raddr;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_valid <= '0;
                    r_last  <= C_NONE;
                    if (w_clamp_ok) begin
                        r_lowest  <= w_clo;
                        r_next    <= w_clo;
                        r_highest <= w_chi;
                        r_prev    <= w_chi;
                    end else begin
                        r_lowest  <= C_NONE;
                        r_next    <= C_NONE;
                        r_highest <= C_NONE;
                        r_prev    <= C_NONE;
                    end
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act    <= i_in_data.action;
                        r_mode   <= i_in_data.alloc_mode;
                        r_status <= ST_DONE;
                        r_oidx   <= '0;
                        r_busy   <= 1'b0;
                        r_state  <= S_DONE;
                        case (i_in_data.action)
                            ACT_ALLOC: begin
                                case (i_in_data.alloc_mode)
                                    MODE_RANDOM: begin
                                        if (r_lowest == C_NONE) begin
                                            r_status <= ST_NONE;
                                        end else begin
                                            r_draws <= '0;
                                            r_state <= S_DRAW;
                                        end
                                    end
                                    MODE_MIN: begin
                                        r_idx   <= r_lowest;
                                        r_state <= S_HINT;
                                    end
                                    MODE_MAX: begin
                                        r_idx   <= r_highest;
                                        r_state <= S_HINT;
                                    end
                                    MODE_PREV: begin
                                        r_idx   <= r_prev;
                                        r_state <= S_HINT;
                                    end
                                    MODE_NEXT: begin
                                        r_idx   <= r_next;
                                        r_state <= S_HINT;
                                    end
                                    default: r_status <= ST_NONE;
                                endcase
                            end
                            ACT_LOCK, ACT_FREE, ACT_TEST: begin
                                if (w_req_in) begin
                                    r_idx   <= w_req;
                                    r_state <= S_RD;
                                end else begin
                                    r_status <= ST_RANGE;
                                end
                            end
                            ACT_CLEAR: begin
                                r_valid <= '0;
                                r_last  <= C_NONE;
                                if (w_clamp_ok) begin
                                    r_lowest  <= w_clo;
                                    r_next    <= w_clo;
                                    r_highest <= w_chi;
                                    r_prev    <= w_chi;
                                end else begin
                                    r_lowest  <= C_NONE;
                                    r_next    <= C_NONE;
                                    r_highest <= C_NONE;
                                    r_prev    <= C_NONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_HINT: begin
                    if (w_idx_clamp) begin
                        r_state <= S_RD;
                    end else begin
                        r_status <= ST_NONE;
                        r_state  <= S_DONE;
                    end
                end
                S_DRAW: begin
                    r_lfsr  <= w_lfsr_nx;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (w_div_done) begin
                        r_idx   <= w_clo + w_div_rem;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_DONE;
                    if (w_write) begin
                        r_valid[r_qa] <= 1'b1;
                    end
                    case (r_act)
                        ACT_ALLOC, ACT_LOCK: begin
                            if (w_b) begin
                                if (r_act == ACT_LOCK) begin
                                    r_status <= ST_STATE;
                                end else if (r_mode == MODE_RANDOM) begin
                                    if (r_draws == C_DRAW_MAX) begin
                                        r_mode  <= MODE_MIN;
                                        r_idx   <= r_lowest;
                                        r_state <= S_HINT;
                                    end else begin
                                        r_draws <= r_draws + 16'd1;
                                        r_state <= S_DRAW;
                                    end
                                end else begin
                                    r_status <= ST_NONE;
                                end
                            end else begin
                                r_oidx <= r_idx[15:0];
                                if (w_idx_clamp) begin
                                    r_last <= r_idx;
                                    if (r_idx < w_chi) begin
                                        r_sw    <= w_up_start[C_OFF_W-1:C_WB];
                                        r_sbit  <= w_up_start[C_WB-1:0];
                                        r_ew    <= w_up_end[C_OFF_W-1:C_WB];
                                        r_ebit  <= w_up_end[C_WB-1:0];
                                        r_state <= S_UP_RD;
                                    end else begin
                                        r_up    <= C_NONE;
                                        r_state <= S_DN_SET;
                                    end
                                end
                            end
                        end
                        ACT_FREE: begin
                            if (w_b) begin
                                r_state <= S_FREEH;
                            end else begin
                                r_status <= ST_STATE;
                            end
                        end
                        ACT_TEST: begin
                            r_busy <= w_b;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_UP_RD: begin
                    r_state <= S_UP_CHK;
                end
                S_UP_CHK: begin
                    if (|w_up_free) begin
                        r_up    <= w_up_hit;
                        r_state <= S_DN_SET;
                    end else if (r_sw == r_ew) begin
                        r_up    <= C_NONE;
                        r_state <= S_DN_SET;
                    end else begin
                        r_sw    <= r_sw + C_WA_W'(1);
                        r_sbit  <= '0;
                        r_state <= S_UP_RD;
                    end
                end
                S_DN_SET: begin
                    if (r_idx <= w_clo) begin
                        r_dn    <= C_NONE;
                        r_state <= S_LOCKH;
                    end else begin
                        r_sw    <= w_dn_start[C_OFF_W-1:C_WB];
                        r_sbit  <= w_dn_start[C_WB-1:0];
                        r_ew    <= w_dn_end[C_OFF_W-1:C_WB];
                        r_ebit  <= w_dn_end[C_WB-1:0];
                        r_state <= S_DN_RD;
                    end
                end
                S_DN_RD: begin
                    r_state <= S_DN_CHK;
                end
                S_DN_CHK: begin
                    if (|w_dn_free) begin
                        r_dn    <= w_dn_hit;
                        r_state <= S_LOCKH;
                    end else if (r_sw == r_ew) begin
                        r_dn    <= C_NONE;
                        r_state <= S_LOCKH;
                    end else begin
                        r_sw    <= r_sw - C_WA_W'(1);
                        r_sbit  <= C_WB'(C_WORD_W - 1);
                        r_state <= S_DN_RD;
                    end
                end
                S_LOCKH: begin
                    r_lowest  <= w_lnew;
                    r_highest <= w_hnew;
                    r_prev    <= (r_dn != C_NONE) ? r_dn : w_hnew;
                    r_next    <= (r_up != C_NONE) ? r_up : w_lnew;
                    r_state   <= S_DONE;
                end
                S_FREEH: begin
                    if (w_idx_clamp) begin
                        if (r_lowest == C_NONE) begin
                            r_lowest  <= r_idx;
                            r_highest <= r_idx;
                            r_prev    <= r_idx;
                            r_next    <= r_idx;
                        end else begin
                            if (r_idx < r_lowest) begin
                                r_lowest <= r_idx;
                            end
                            if (r_idx > r_highest) begin
                                r_highest <= r_idx;
                            end
                            if ((r_idx > r_prev && r_idx < r_last)
                                || (r_prev > r_last && (r_idx > r_prev || r_idx < r_last))
                                || (r_prev == r_last)) begin
                                r_prev <= r_idx;
                            end
                            if ((r_idx < r_next && r_idx > r_last)
                                || (r_next < r_last && (r_idx < r_next || r_idx > r_last))
                                || (r_next == r_last)) begin
                                r_next <= r_idx;
                            end
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status    <= r_status;
                        r_out.out_index <= r_oidx;
                        r_out.busy_res  <= r_busy;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE: begin
                        r_base  <= i_cfg_data;
                        r_state <= S_INIT;
                    end
                    CFG_CLO: begin
                        r_clamp_lo <= i_cfg_data;
                        r_state    <= S_INIT;
                    end
                    CFG_CHI: begin
                        r_clamp_hi <= i_cfg_data;
                        r_state    <= S_INIT;
                    end
                    default:  r_base     <= r_base;
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: verif/tb.sv
// self-checking testbench of the bitmap index allocator with an internal allocator model
module tb import bia_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_BASE;
    logic [15:0] i_cfg_data = '0;

    bitmap_index_allocator DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // allocator model state
    bit          m_busy [C_COUNT];
    int unsigned m_base, m_clo, m_chi;
    int unsigned m_lowest, m_highest, m_prev, m_next, m_last;
    int unsigned m_lfsr;

    t_in  pending_beats [$];
    t_out expected_beats [$];
    int   errors = 0;
    int   cycle = 0;
    int   hold_off = 0;
    bit   long_hold_done = 1'b0;

    function automatic int unsigned win_lo_clamp();
        return (m_clo > m_base) ? m_clo : m_base;
    endfunction

    function automatic int unsigned win_hi_clamp();
        int unsigned e;
        e = m_base + C_COUNT - 1;
        return (m_chi < e) ? m_chi : e;
    endfunction

    function automatic bit in_win(int unsigned i);
        return i >= m_base && (i - m_base) < C_COUNT;
    endfunction

    function automatic bit taken(int unsigned i);
        if (!in_win(i)) return 1'b0;
        return m_busy[i - m_base];
    endfunction

    function automatic bit in_clamp(int unsigned i);
        return i >= win_lo_clamp() && i <= win_hi_clamp();
    endfunction

    function automatic int unsigned free_below(int unsigned i, int unsigned fl, int unsigned dflt);
        while (i > fl) begin
            i--;
            if (!taken(i)) return i;
        end
        return dflt;
    endfunction

    function automatic int unsigned free_above(int unsigned i, int unsigned cl, int unsigned dflt);
        while (i < cl) begin
            i++;
            if (!taken(i)) return i;
        end
        return dflt;
    endfunction

    function automatic void empty_map();
        foreach (m_busy[k]) m_busy[k] = 1'b0;
        m_last = C_NONE;
        if (win_lo_clamp() <= win_hi_clamp()) begin
            m_lowest = win_lo_clamp();
            m_next = m_lowest;
            m_highest = win_hi_clamp();
            m_prev = m_highest;
        end else begin
            m_lowest = C_NONE;
            m_next = C_NONE;
            m_highest = C_NONE;
            m_prev = C_NONE;
        end
    endfunction

    function automatic int unsigned lfsr_step();
        int unsigned r, b;
        r = m_lfsr & 16'hFFFF;
        b = (r ^ (r >> 2) ^ (r >> 3) ^ (r >> 5)) & 1;
        m_lfsr = ((r >> 1) | (b << 15)) & 16'hFFFF;
        return m_lfsr;
    endfunction

    function automatic void take(int unsigned i);
        m_busy[i - m_base] = 1'b1;
        if (!in_clamp(i)) return;
        m_last = i;
        if (i == m_lowest) m_lowest = free_above(i, win_hi_clamp(), C_NONE);
        if (i == m_highest) m_highest = free_below(i, win_lo_clamp(), C_NONE);
        m_prev = free_below(i, win_lo_clamp(), m_highest);
        m_next = free_above(i, win_hi_clamp(), m_lowest);
    endfunction

    function automatic void release_idx(int unsigned i);
        m_busy[i - m_base] = 1'b0;
        if (!in_clamp(i)) return;
        if (m_lowest == C_NONE) begin
            m_lowest = i;
            m_highest = i;
            m_prev = i;
            m_next = i;
            return;
        end
        if (i < m_lowest) m_lowest = i;
        if (i > m_highest) m_highest = i;
        if ((i > m_prev && i < m_last) || (m_prev > m_last && (i > m_prev || i < m_last))
                || m_prev == m_last)
            m_prev = i;
        if ((i < m_next && i > m_last) || (m_next < m_last && (i < m_next || i > m_last))
                || m_next == m_last)
            m_next = i;
    endfunction

    function automatic int unsigned random_pick();
        int unsigned lo, span, i;
        lo = win_lo_clamp();
        span = win_hi_clamp() - lo + 1;
        if (m_lowest == C_NONE) return C_NONE;
        for (int n = 0; n < 65535; n++) begin
            i = lo + lfsr_step() % span;
            if (!taken(i)) return i;
        end
        return m_lowest;
    endfunction

    function automatic t_out predict_beat(t_in b);
        t_out r;
        int unsigned i, q;
        r = '0;
        q = b.req_index;
        case (b.action)
            ACT_ALLOC: begin
                case (b.alloc_mode)
                    MODE_RANDOM: i = random_pick();
                    MODE_MIN:    i = m_lowest;
                    MODE_MAX:    i = m_highest;
                    MODE_PREV:   i = m_prev;
                    MODE_NEXT:   i = m_next;
                    default:     i = C_NONE;
                endcase
                if (i == C_NONE || !in_clamp(i) || taken(i)) begin
                    r.status = ST_NONE;
                end else begin
                    take(i);
                    r.out_index = i[15:0];
                end
            end
            ACT_LOCK: begin
                if (!in_win(q)) r.status = ST_RANGE;
                else if (taken(q)) r.status = ST_STATE;
                else begin
                    take(q);
                    r.out_index = q[15:0];
                end
            end
            ACT_FREE: begin
                if (!in_win(q)) r.status = ST_RANGE;
                else if (!taken(q)) r.status = ST_STATE;
                else release_idx(q);
            end
            ACT_TEST: begin
                if (!in_win(q)) r.status = ST_RANGE;
                else r.busy_res = taken(q);
            end
            ACT_CLEAR: empty_map();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
    endtask

    // driver
    int gap = 0;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_beats.push_back(predict_beat(i_in_data));
                void'(pending_beats.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
            end else if (gap > 0) begin
                gap <= gap - 1;
                i_in_valid <= 1'b0;
            end else if ((i_in_valid && !o_in_stall ? pending_beats.size() > 0
                                                     : pending_beats.size() > 0)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_beats[0];
                if ($urandom_range(0, 9) < 3)
                    gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                          : $urandom_range(1, 4);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall and monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    if (o_out_data.status !== expected_beats[0].status)
                        report_mismatch("status", o_out_data.status, expected_beats[0].status);
                    if (o_out_data.out_index !== expected_beats[0].out_index)
                        report_mismatch("out_index", o_out_data.out_index,
                                        expected_beats[0].out_index);
                    if (o_out_data.busy_res !== expected_beats[0].busy_res)
                        report_mismatch("busy_res", o_out_data.busy_res,
                                        expected_beats[0].busy_res);
                    void'(expected_beats.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else if (!long_hold_done && pending_beats.size() > 200) begin
                long_hold_done <= 1'b1;
                hold_off <= 600;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 2999) == 0) begin
                hold_off <= 600;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                hold_off <= $urandom_range(20, 150);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 9) < 2);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in mk(logic [2:0] a, logic [2:0] m, logic [15:0] q);
        t_in b;
        b.action = a;
        b.alloc_mode = m;
        b.req_index = q;
        return b;
    endfunction

    function automatic logic [15:0] pick_req();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'(win_lo_clamp() + $urandom_range(0, 40));
        if (r < 90) return 16'(m_base + $urandom_range(0, C_COUNT - 1));
        return 16'($urandom);
    endfunction

    task automatic settle();
        while (pending_beats.size() > 0 || i_in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE: m_base = v;
            CFG_CLO:  m_clo = v;
            default:  m_chi = v;
        endcase
        empty_map();
        repeat (4) @(posedge i_clk);
    endtask

    // random phase: pushing items, since the model runs at acceptance the
    // request picks use the current window only
    task automatic random_phase(int n);
        int unsigned a;
        for (int k = 0; k < n; k++) begin
            a = $urandom_range(0, 99);
            if (a < 40) pending_beats.push_back(mk(ACT_ALLOC, 3'($urandom_range(0, 4)), 16'($urandom)));
            else if (a < 60) pending_beats.push_back(mk(ACT_LOCK, 3'($urandom), pick_req()));
            else if (a < 82) pending_beats.push_back(mk(ACT_FREE, 3'($urandom), pick_req()));
            else if (a < 95) pending_beats.push_back(mk(ACT_TEST, 3'($urandom), pick_req()));
            else if (a < 97) pending_beats.push_back(mk(ACT_CLEAR, 3'($urandom), 16'($urandom)));
            else pending_beats.push_back(mk(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                            16'($urandom)));
        end
    endtask

    initial begin
        m_base = 0;
        m_clo = 0;
        m_chi = 1023;
        m_lfsr = C_LFSR_RST;
        empty_map();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed: every action, every mode, window edges and odd codes
        pending_beats.push_back(mk(ACT_ALLOC, MODE_MIN, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_MAX, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_PREV, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_NEXT, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_RANDOM, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, 3'd5, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, 3'd7, 16'hFFFF));
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'd0));
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'd1023));
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'd1024));
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'hFFFF));
        pending_beats.push_back(mk(ACT_TEST, MODE_MIN, 16'd0));
        pending_beats.push_back(mk(ACT_TEST, MODE_MIN, 16'd500));
        pending_beats.push_back(mk(ACT_TEST, MODE_MIN, 16'hFFFF));
        pending_beats.push_back(mk(ACT_FREE, MODE_MIN, 16'd0));
        pending_beats.push_back(mk(ACT_FREE, MODE_MIN, 16'd0));
        pending_beats.push_back(mk(ACT_FREE, MODE_MIN, 16'd2000));
        pending_beats.push_back(mk(ACT_FREE, MODE_MIN, 16'd1023));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_PREV, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_NEXT, 16'h0));
        pending_beats.push_back(mk(ACT_CLEAR, MODE_MIN, 16'h0));
        pending_beats.push_back(mk(3'd5, MODE_MIN, 16'h1234));
        pending_beats.push_back(mk(3'd7, 3'd7, 16'hFFFF));
        settle();

        // small clamp window so allocation exhausts it and random retries
        write_reg(CFG_CLO, 16'd10);
        write_reg(CFG_CHI, 16'd25);
        for (int k = 0; k < 20; k++) pending_beats.push_back(mk(ACT_ALLOC, MODE_RANDOM, 16'h0));
        pending_beats.push_back(mk(ACT_ALLOC, MODE_MIN, 16'h0));
        random_phase(350);
        settle();

        // window at the top, clamps at extremes
        write_reg(CFG_BASE, 16'd64512);
        write_reg(CFG_CLO, 16'd0);
        write_reg(CFG_CHI, 16'hFFFF);
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'hFFFF));
        pending_beats.push_back(mk(ACT_LOCK, MODE_MIN, 16'd64511));
        random_phase(350);
        settle();

        // empty clamp window
        write_reg(CFG_CLO, 16'd2000);
        write_reg(CFG_CHI, 16'd1000);
        random_phase(150);
        settle();

        // odd base and narrow clamp
        write_reg(CFG_BASE, 16'd12345);
        write_reg(CFG_CLO, 16'd12400);
        write_reg(CFG_CHI, 16'd12460);
        random_phase(350);
        settle();

        write_reg(CFG_BASE, 16'd0);
        write_reg(CFG_CLO, 16'd0);
        write_reg(CFG_CHI, 16'd63);
        random_phase(350);
        settle();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
